// ----- src/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg - shared types and codes for the linear probe hash table
// Word layouts, slot state codes, command and status codes.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int SLOTS           = 26;
  localparam int SLOT_W          = 5;
  localparam int LETTER_W        = 5;
  localparam int LETTER_COUNT    = 26;
  localparam int MAX_KEY_LETTERS = 10;
  localparam int KEY_W           = 50;
  localparam int LEN_W           = 4;

  // slot states
  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_USED = 2'd1;
  localparam logic [1:0] ST_GONE = 2'd2;

  // commands
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_DUMP = 2'd2;

  // result status
  localparam logic [2:0] STAT_ADDED     = 3'd0;
  localparam logic [2:0] STAT_PRESENT   = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_DELETED   = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
  localparam logic [2:0] STAT_BAD_KEY   = 3'd5;
  localparam logic [2:0] STAT_ENTRY     = 3'd6;
  localparam logic [2:0] STAT_EMPTY     = 3'd7;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key_chars;
    logic [LEN_W-1:0] key_len;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  out_key;
    logic [LEN_W-1:0]  out_len;
    logic              last;
  } out_word_t;

  // checked key, home slot and masked letters
  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] home;
    logic [KEY_W-1:0]  key;
  } key_info_t;

  // one slot as held in the table memory
  typedef struct packed {
    logic [1:0]       st;
    logic [LEN_W-1:0] len;
    logic [KEY_W-1:0] key;
  } slot_entry_t;

endpackage

// ----- src/linear_probe_hash_table.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table - open-addressing key table with linear probing
// 26 slots of short lowercase keys; add, delete and dump commands.
// ----------------------------------------------------------------------------
// Use:
//   in_valid/in_stall/in_word carries one command word (cmd, key_chars,
//   key_len). out_valid/out_stall/out_word carries result words; last marks
//   the final word caused by a command. Add and delete give one word, dump
//   gives one word per occupied slot in slot order, or a single empty word.
// Timing:
//   The accept cycle issues the first table read. Each probe then reads
//   one slot through the registered memory read port; add and delete make
//   1 to 26 probes, a bad key or unknown command passes through S_BAD and a
//   dump sweeps all slots, then a tail state sends the final word. The next
//   command is accepted the cycle after the last result enters the output
//   register, while that word may still wait to be taken.
// Reset:
//   Valid bits in the slot memory clear at once, so all slots read as never
//   used; no clearing pass is needed.
// Stall:
//   A stalled output holds its word; the sequencer waits on the same slot
//   (re-reading it) until the register can take the next word.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int MAX_KEY_LETTERS = lpht_pkg::MAX_KEY_LETTERS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpht_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output lpht_pkg::out_word_t out_word
);

  localparam int SW = lpht_pkg::SLOT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(lpht_pkg::SLOTS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;  // one probe / sweep step per cycle unless the output stalls
  localparam logic [1:0] S_DTAIL = 2'd2;  // dump: final word
  localparam logic [1:0] S_BAD   = 2'd3;  // bad key or unknown command

  logic [1:0] state_r, state_nxt;

  // command context
  logic [1:0]                  cmd_r, cmd_nxt;
  logic [lpht_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [lpht_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [SW-1:0]               idx_r, idx_nxt;    // slot whose data is in rdata
  logic [SW-1:0]               cnt_r, cnt_nxt;    // probes done in this lap
  logic                        have_free_r, have_free_nxt;
  logic [SW-1:0]               free_slot_r, free_slot_nxt;

  // dump: entry held back until we know whether it is the last
  logic                        pend_v_r, pend_v_nxt;
  lpht_pkg::slot_entry_t       pend_r, pend_nxt;
  logic [SW-1:0]               pend_slot_r, pend_slot_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  lpht_pkg::out_word_t         out_word_r, out_word_nxt;

  lpht_pkg::key_info_t         kinfo;
  lpht_pkg::slot_entry_t       rdata, wdata;
  logic                        we;
  logic [SW-1:0]               waddr, raddr;

  logic                        in_acc, out_free, emit;
  lpht_pkg::out_word_t         emit_word;
  logic                        used, match, lap_end, cand_have;
  logic [SW-1:0]               cand_slot, idx_inc;

  lpht_key_check #(
    .MAX_KEY_LETTERS (MAX_KEY_LETTERS)
  ) u_key (
    .key_chars (in_word.key_chars),
    .key_len   (in_word.key_len),
    .info      (kinfo)
  );

  lpht_slot_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign idx_inc   = (idx_r == LAST_SLOT) ? '0 : idx_r + 1'b1;
  assign used      = (rdata.st == lpht_pkg::ST_USED);
  assign match     = used && (rdata.len == len_r) && (rdata.key == key_r);
  assign lap_end   = (cnt_r == LAST_SLOT);
  assign cand_have = have_free_r || !used;
  assign cand_slot = have_free_r ? free_slot_r : idx_r;

  function automatic lpht_pkg::out_word_t mk_word(logic [2:0] st, logic [SW-1:0] sl);
    lpht_pkg::out_word_t w;
    w         = '0;
    w.status  = st;
    w.slot    = sl;
    w.last    = 1'b1;
    return w;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    have_free_nxt = have_free_r;
    free_slot_nxt = free_slot_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    pend_slot_nxt = pend_slot_r;
    raddr         = idx_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata.st      = lpht_pkg::ST_USED;
    wdata.len     = len_r;
    wdata.key     = key_r;
    emit          = 1'b0;
    emit_word     = '0;

    case (state_r)
      S_IDLE: begin
        raddr = (in_word.cmd == lpht_pkg::CMD_DUMP) ? '0 : kinfo.home;
        if (in_acc) begin
          cmd_nxt       = in_word.cmd;
          key_nxt       = kinfo.key;
          len_nxt       = in_word.key_len;
          idx_nxt       = raddr;
          cnt_nxt       = '0;
          have_free_nxt = 1'b0;
          pend_v_nxt    = 1'b0;
          if (in_word.cmd == lpht_pkg::CMD_DUMP) begin
            state_nxt = S_EVAL;
          end else if ((in_word.cmd == lpht_pkg::CMD_ADD ||
                        in_word.cmd == lpht_pkg::CMD_DEL) && kinfo.ok) begin
            state_nxt = S_EVAL;
          end else begin
            state_nxt = S_BAD;
          end
        end
      end

      S_EVAL: begin
        if (cmd_r == lpht_pkg::CMD_DUMP) begin
          if (!(used && pend_v_r && !out_free)) begin
            if (used) begin
              if (pend_v_r) begin
                emit              = 1'b1;
                emit_word.status  = lpht_pkg::STAT_ENTRY;
                emit_word.slot    = pend_slot_r;
                emit_word.out_key = pend_r.key;
                emit_word.out_len = pend_r.len;
                emit_word.last    = 1'b0;
              end
              pend_v_nxt    = 1'b1;
              pend_nxt      = rdata;
              pend_slot_nxt = idx_r;
            end
            if (idx_r == LAST_SLOT) begin
              state_nxt = S_DTAIL;
            end else begin
              idx_nxt = idx_inc;
              raddr   = idx_inc;
            end
          end
        end else if (match || rdata.st == lpht_pkg::ST_FREE || lap_end) begin
          // probe ends here; hold on this slot until the output can load
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
            if (match) begin
              if (cmd_r == lpht_pkg::CMD_ADD) begin
                emit_word = mk_word(lpht_pkg::STAT_PRESENT, idx_r);
              end else begin
                we        = 1'b1;
                wdata     = rdata;
                wdata.st  = lpht_pkg::ST_GONE;
                emit_word = mk_word(lpht_pkg::STAT_DELETED, idx_r);
              end
            end else if (cmd_r == lpht_pkg::CMD_ADD) begin
              if (cand_have) begin
                we        = 1'b1;
                waddr     = cand_slot;
                emit_word = mk_word(lpht_pkg::STAT_ADDED, cand_slot);
              end else begin
                emit_word = mk_word(lpht_pkg::STAT_FULL, '0);
              end
            end else begin
              emit_word = mk_word(lpht_pkg::STAT_NOT_FOUND, '0);
            end
          end
        end else begin
          // occupied by another key, or tombstone: keep probing
          if (!have_free_r && rdata.st == lpht_pkg::ST_GONE) begin
            have_free_nxt = 1'b1;
            free_slot_nxt = idx_r;
          end
          idx_nxt = idx_inc;
          raddr   = idx_inc;
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_DTAIL: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (pend_v_r) begin
            emit_word         = mk_word(lpht_pkg::STAT_ENTRY, pend_slot_r);
            emit_word.out_key = pend_r.key;
            emit_word.out_len = pend_r.len;
          end else begin
            emit_word = mk_word(lpht_pkg::STAT_EMPTY, '0);
          end
        end
      end

      S_BAD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_word = mk_word(lpht_pkg::STAT_BAD_KEY, '0);
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_word_nxt  = emit_word;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    len_r       <= len_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    have_free_r <= have_free_nxt;
    free_slot_r <= free_slot_nxt;
    pend_r      <= pend_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- src/lpht_key_check.sv -----
// ----------------------------------------------------------------------------
// lpht_key_check - key validation
// Checks length and letter codes, masks unused letters, picks home slot.
// ----------------------------------------------------------------------------
module lpht_key_check #(
  parameter int MAX_KEY_LETTERS = lpht_pkg::MAX_KEY_LETTERS
) (
  input  logic [lpht_pkg::KEY_W-1:0] key_chars,
  input  logic [lpht_pkg::LEN_W-1:0] key_len,
  output lpht_pkg::key_info_t        info
);

  localparam int LW    = lpht_pkg::LETTER_W;
  localparam int LET_N = MAX_KEY_LETTERS;
  // letters past the field read as zero
  localparam int EXT_W = (LET_N * LW > lpht_pkg::KEY_W) ? LET_N * LW : lpht_pkg::KEY_W;

  logic [EXT_W-1:0] ext;
  logic [EXT_W-1:0] masked;
  logic [LW-1:0]    code;
  logic             codes_ok;

  assign ext = EXT_W'(key_chars);

  always_comb begin
    masked    = '0;
    codes_ok  = 1'b1;
    info.home = '0;
    for (int i = 0; i < LET_N; i++) begin
      code = ext[i*LW +: LW];
      if (i < int'(key_len)) begin
        if (code >= LW'(lpht_pkg::LETTER_COUNT)) begin
          codes_ok = 1'b0;
        end
        masked[i*LW +: LW] = code;
      end
      if (i == int'(key_len) - 1) begin
        info.home = lpht_pkg::SLOT_W'(code);
      end
    end
    info.key = masked[lpht_pkg::KEY_W-1:0];
    info.ok  = (key_len != '0) && (int'(key_len) <= LET_N) && codes_ok;
  end

endmodule

// ----- src/lpht_slot_ram.sv -----
// ----------------------------------------------------------------------------
// lpht_slot_ram - slot table memory
// One write and one registered read port; per-slot valid bits so that an
// unwritten slot reads as never used.
// ----------------------------------------------------------------------------
module lpht_slot_ram (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        we,
  input  logic [lpht_pkg::SLOT_W-1:0] waddr,
  input  lpht_pkg::slot_entry_t       wdata,
  input  logic [lpht_pkg::SLOT_W-1:0] raddr,
  output lpht_pkg::slot_entry_t       rdata
);

  lpht_pkg::slot_entry_t       mem [lpht_pkg::SLOTS];
  lpht_pkg::slot_entry_t       q_r;
  logic [lpht_pkg::SLOTS-1:0]  valid_r;
  logic                        q_valid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      q_valid_r <= valid_r[raddr];
    end
  end

  always_comb begin
    rdata = q_r;
    if (!q_valid_r) begin
      rdata.st = lpht_pkg::ST_FREE;
    end
  end

endmodule

// ----- src/lpht_checker.sv -----
// ----------------------------------------------------------------------------
// lpht_checker - port-level checks for the hash table
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module lpht_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input lpht_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input lpht_pkg::out_word_t out_word
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // one command at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command accepted while previous one in progress");

  // only dump entries can be followed by more words
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != lpht_pkg::STAT_ENTRY |-> out_word.last)
    else $error("non-entry result not marked last");

  // slot index within the table
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.slot <= lpht_pkg::SLOT_W'(lpht_pkg::SLOTS - 1))
    else $error("slot index out of range");

  // key fields only carried by dump entries
  a_key0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != lpht_pkg::STAT_ENTRY
      |-> out_word.out_key == '0 && out_word.out_len == '0)
    else $error("key data on a non-entry result");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
